>>> design/rvx_pkg.sv
// Shared types, constants and helpers for the RV64IM execute unit.
package rvx_pkg;

    localparam int DIV_STEPS = 64;
    localparam int MUL_STAGE = 3;

    localparam logic [6:0] OP_LOAD     = 7'h03;
    localparam logic [6:0] OP_MISC_MEM = 7'h0f;
    localparam logic [6:0] OP_IMM      = 7'h13;
    localparam logic [6:0] OP_AUIPC    = 7'h17;
    localparam logic [6:0] OP_IMM32    = 7'h1b;
    localparam logic [6:0] OP_STORE    = 7'h23;
    localparam logic [6:0] OP_REG      = 7'h33;
    localparam logic [6:0] OP_LUI      = 7'h37;
    localparam logic [6:0] OP_REG32    = 7'h3b;
    localparam logic [6:0] OP_BRANCH   = 7'h63;
    localparam logic [6:0] OP_JALR     = 7'h67;
    localparam logic [6:0] OP_JAL      = 7'h6f;
    localparam logic [6:0] OP_SYSTEM   = 7'h73;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [5:0] F6_BASE   = 6'h00;
    localparam logic [5:0] F6_ALT    = 6'h10;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ILL = 2'd1;
    localparam logic [1:0] ST_SYS = 2'd2;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    typedef enum logic [1:0] {
        RSEL_ALU,
        RSEL_MUL,
        RSEL_QUO,
        RSEL_REM
    } t_rsel;

    typedef struct packed {
        logic [31:0] instruction;
        logic [63:0] inst_address;
        logic [63:0] src1_value;
        logic [63:0] src2_value;
    } t_in;

    typedef struct packed {
        logic [4:0]  dest_index;
        logic        dest_write;
        logic [63:0] dest_value;
        logic [63:0] next_address;
        logic [1:0]  mem_kind;
        logic [1:0]  mem_size_log;
        logic        mem_zero_extend;
        logic [63:0] mem_address;
        logic [63:0] store_data;
        logic [1:0]  status;
    } t_out;

    // everything but the value, carried down the pipe
    typedef struct packed {
        logic [4:0]  dest_index;
        logic        dest_write;
        logic [63:0] next_address;
        logic [1:0]  mem_kind;
        logic [1:0]  mem_size_log;
        logic        mem_zero_extend;
        logic [63:0] mem_address;
        logic [63:0] store_data;
        logic [1:0]  status;
        t_rsel       rsel;
        logic        word;
        logic        neg_q;
        logic        neg_r;
    } t_ctl;

    function automatic logic [63:0] sx32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

>>> design/rvx_mul.sv
// Pipelined 64x64 multiplier built from 32x32 partial products.
module rvx_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_sa,
    input  logic        i_sb,
    input  logic        i_hi,
    output logic [63:0] o_res
);
    import rvx_pkg::*;

    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic [63:0]  r_a1, r_b1, r_a2, r_b2;
    logic         r_sa1, r_sb1, r_hi1, r_sa2, r_sb2, r_hi2;
    logic [127:0] r_prod;
    logic [63:0]  s_hi;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= i_a[31:0] * i_b[31:0];
            r_lh  <= i_a[31:0] * i_b[63:32];
            r_hl  <= i_a[63:32] * i_b[31:0];
            r_hh  <= i_a[63:32] * i_b[63:32];
            r_a1  <= i_a;
            r_b1  <= i_b;
            r_sa1 <= i_sa;
            r_sb1 <= i_sb;
            r_hi1 <= i_hi;
            r_prod <= {64'b0, r_ll} + {32'b0, r_lh, 32'b0} + {32'b0, r_hl, 32'b0}
                      + {r_hh, 64'b0};
            r_a2  <= r_a1;
            r_b2  <= r_b1;
            r_sa2 <= r_sa1;
            r_sb2 <= r_sb1;
            r_hi2 <= r_hi1;
        end
    end

    // signed high half: unsigned high minus the other operand per negative input
    always_comb begin
        s_hi = r_prod[127:64]
               - ((r_sa2 && r_a2[63]) ? r_b2 : 64'b0)
               - ((r_sb2 && r_b2[63]) ? r_a2 : 64'b0);
        o_res = r_hi2 ? s_hi : r_prod[63:0];
    end

endmodule

>>> design/rvx_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rvx_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_n,
    input  logic [63:0] i_d,
    output logic [63:0] o_q,
    output logic [63:0] o_r
);
    import rvx_pkg::*;

    // upper half partial remainder, lower half dividend bits then quotient
    logic [127:0] r_acc [0:DIV_STEPS-1];
    logic [63:0]  r_dvs [0:DIV_STEPS-2];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [127:0] s_src;
        logic [63:0]  s_dvs;
        logic [64:0]  s_top;
        logic [65:0]  s_diff;
        logic [127:0] s_nxt;

        if (k == 0) begin : g_first
            assign s_src = {64'b0, i_n};
            assign s_dvs = i_d;
        end else begin : g_rest
            assign s_src = r_acc[k-1];
            assign s_dvs = r_dvs[k-1];
        end

        always_comb begin
            s_top  = s_src[127:63];
            s_diff = {1'b0, s_top} - {2'b0, s_dvs};
            if (!s_diff[65]) begin
                s_nxt = {s_diff[63:0], s_src[62:0], 1'b1};
            end else begin
                s_nxt = {s_top[63:0], s_src[62:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= s_nxt;
            end
        end

        if (k < DIV_STEPS - 1) begin : g_dvs
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dvs[k] <= s_dvs;
                end
            end
        end
    end

    assign o_q = r_acc[DIV_STEPS-1][63:0];
    assign o_r = r_acc[DIV_STEPS-1][127:64];

endmodule

>>> design/rv64im_execute_unit.sv
// RV64IM execute unit: decode, ALU, multiply and divide in one deep pipeline.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+--------
//  in      | i_valid | o_stall | i_data
//  out     | o_valid | i_stall | o_data
//
// One transaction per cycle while the output is not stalled; every instruction
// travels the full pipe alongside the 64-stage divider, so all take equally long.
// Synchronous active-low reset empties the pipe; data registers are not reset.
// A stalled output freezes the whole pipe, so o_stall follows i_stall while
// the output register holds a transaction.
module rv64im_execute_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rvx_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rvx_pkg::t_out o_data
);
    import rvx_pkg::*;

    logic               s_adv;
    logic [DIV_STEPS:0] r_vld;
    t_ctl               r_ctl [0:DIV_STEPS];
    logic [63:0]        r_val [0:DIV_STEPS];
    logic [63:0]        r_ma, r_mb, r_dn, r_dd;
    logic               r_msa, r_msb, r_mhi;
    logic               r_out_vld;
    t_out               r_out;

    // decode
    logic [31:0] w;
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [5:0]  f6;
    logic [63:0] a, b, pc, pc4, immi, imms, immb, immu, immj, op2;
    logic [5:0]  sh;
    logic [63:0] sum, dif, xa, xb;
    logic        lt_s, lt_u, eq;
    t_ctl        n_ctl;
    logic [63:0] n_val, n_dn, n_dd;
    logic        n_msa, n_msb, n_mhi, ill, sys, take, dsign;

    always_comb begin
        w    = i_data.instruction;
        pc   = i_data.inst_address;
        a    = i_data.src1_value;
        b    = i_data.src2_value;
        opc  = (w[1:0] == 2'b11) ? w[6:0] : 7'h00;
        f3   = w[14:12];
        f7   = w[31:25];
        f6   = w[31:26];
        pc4  = pc + 64'd4;
        immi = {{52{w[31]}}, w[31:20]};
        imms = {{52{w[31]}}, w[31:25], w[11:7]};
        immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        immu = {{32{w[31]}}, w[31:12], 12'b0};
        immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        op2  = (opc == OP_REG || opc == OP_REG32 || opc == OP_BRANCH) ? b : immi;
        sh   = op2[5:0];
        sum  = a + op2;
        dif  = a - b;
        lt_s = $signed(a) < $signed(op2);
        lt_u = a < op2;
        eq   = a == b;

        ill = 1'b0;
        sys = 1'b0;
        take = 1'b0;
        dsign = 1'b0;
        n_val = 64'b0;
        n_msa = 1'b0;
        n_msb = 1'b0;
        n_mhi = 1'b0;
        n_ctl = '0;
        n_ctl.dest_index   = w[11:7];
        n_ctl.next_address = pc4;
        n_ctl.mem_kind     = MEM_NONE;
        n_ctl.status       = ST_OK;
        n_ctl.rsel         = RSEL_ALU;

        unique case (opc)
            OP_REG: begin
                n_ctl.dest_write = 1'b1;
                if (f7 == F7_MULDIV) begin
                    unique case (f3)
                        3'd0: n_ctl.rsel = RSEL_MUL;
                        3'd1: begin
                            n_ctl.rsel = RSEL_MUL; n_mhi = 1'b1; n_msa = 1'b1; n_msb = 1'b1;
                        end
                        3'd2: begin
                            n_ctl.rsel = RSEL_MUL; n_mhi = 1'b1; n_msa = 1'b1;
                        end
                        3'd3: begin
                            n_ctl.rsel = RSEL_MUL; n_mhi = 1'b1;
                        end
                        3'd4: begin n_ctl.rsel = RSEL_QUO; dsign = 1'b1; end
                        3'd5: n_ctl.rsel = RSEL_QUO;
                        3'd6: begin n_ctl.rsel = RSEL_REM; dsign = 1'b1; end
                        default: n_ctl.rsel = RSEL_REM;
                    endcase
                end else if (f7 == F7_BASE) begin
                    unique case (f3)
                        3'd0: n_val = sum;
                        3'd1: n_val = a << sh;
                        3'd2: n_val = {63'b0, lt_s};
                        3'd3: n_val = {63'b0, lt_u};
                        3'd4: n_val = a ^ b;
                        3'd5: n_val = a >> sh;
                        3'd6: n_val = a | b;
                        default: n_val = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    n_val = dif;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    n_val = 64'($signed(a) >>> sh);
                end else begin
                    ill = 1'b1;
                end
            end
            OP_REG32: begin
                n_ctl.dest_write = 1'b1;
                n_ctl.word = 1'b1;
                if (f7 == F7_MULDIV) begin
                    unique case (f3)
                        3'd0: n_ctl.rsel = RSEL_MUL;
                        3'd4: begin n_ctl.rsel = RSEL_QUO; dsign = 1'b1; end
                        3'd5: n_ctl.rsel = RSEL_QUO;
                        3'd6: begin n_ctl.rsel = RSEL_REM; dsign = 1'b1; end
                        3'd7: n_ctl.rsel = RSEL_REM;
                        default: ill = 1'b1;
                    endcase
                end else if (f7 == F7_BASE && f3 == 3'd0) begin
                    n_val = sx32(sum);
                end else if (f7 == F7_BASE && f3 == 3'd1) begin
                    n_val = sx32(a << sh[4:0]);
                end else if (f7 == F7_BASE && f3 == 3'd5) begin
                    n_val = sx32({32'b0, a[31:0] >> sh[4:0]});
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    n_val = sx32(dif);
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    n_val = sx32({32'b0, 32'($signed(a[31:0]) >>> sh[4:0])});
                end else begin
                    ill = 1'b1;
                end
            end
            OP_IMM: begin
                n_ctl.dest_write = 1'b1;
                unique case (f3)
                    3'd0: n_val = sum;
                    3'd1: begin
                        if (f6 == F6_BASE) n_val = a << sh;
                        else ill = 1'b1;
                    end
                    3'd2: n_val = {63'b0, lt_s};
                    3'd3: n_val = {63'b0, lt_u};
                    3'd4: n_val = a ^ immi;
                    3'd5: begin
                        if (f6 == F6_BASE) n_val = a >> sh;
                        else if (f6 == F6_ALT) n_val = 64'($signed(a) >>> sh);
                        else ill = 1'b1;
                    end
                    3'd6: n_val = a | immi;
                    default: n_val = a & immi;
                endcase
            end
            OP_IMM32: begin
                n_ctl.dest_write = 1'b1;
                if (f3 == 3'd0) begin
                    n_val = sx32(sum);
                end else if (f3 == 3'd1 && f7 == F7_BASE) begin
                    n_val = sx32(a << sh[4:0]);
                end else if (f3 == 3'd5 && f7 == F7_BASE) begin
                    n_val = sx32({32'b0, a[31:0] >> sh[4:0]});
                end else if (f3 == 3'd5 && f7 == F7_ALT) begin
                    n_val = sx32({32'b0, 32'($signed(a[31:0]) >>> sh[4:0])});
                end else begin
                    ill = 1'b1;
                end
            end
            OP_LUI: begin
                n_ctl.dest_write = 1'b1;
                n_val = immu;
            end
            OP_AUIPC: begin
                n_ctl.dest_write = 1'b1;
                n_val = pc + immu;
            end
            OP_JAL: begin
                n_ctl.dest_write = 1'b1;
                n_val = pc4;
                n_ctl.next_address = pc + immj;
            end
            OP_JALR: begin
                if (f3 == 3'd0) begin
                    n_ctl.dest_write = 1'b1;
                    n_val = pc4;
                    n_ctl.next_address = {sum[63:1], 1'b0};
                end else begin
                    ill = 1'b1;
                end
            end
            OP_BRANCH: begin
                unique case (f3)
                    3'd0: take = eq;
                    3'd1: take = !eq;
                    3'd4: take = lt_s;
                    3'd5: take = !lt_s;
                    3'd6: take = lt_u;
                    3'd7: take = !lt_u;
                    default: ill = 1'b1;
                endcase
                if (take) n_ctl.next_address = pc + immb;
            end
            OP_LOAD: begin
                if (f3 == 3'd7) begin
                    ill = 1'b1;
                end else begin
                    n_ctl.mem_kind        = MEM_LOAD;
                    n_ctl.mem_size_log    = f3[1:0];
                    n_ctl.mem_zero_extend = f3[2];
                    n_ctl.mem_address     = sum;
                end
            end
            OP_STORE: begin
                if (f3[2]) begin
                    ill = 1'b1;
                end else begin
                    n_ctl.mem_kind     = MEM_STORE;
                    n_ctl.mem_size_log = f3[1:0];
                    n_ctl.mem_address  = a + imms;
                    n_ctl.store_data   = b;
                end
            end
            OP_MISC_MEM: begin
                if (f3 > 3'd1) ill = 1'b1;
            end
            OP_SYSTEM: sys = 1'b1;
            default: ill = 1'b1;
        endcase

        if (ill || sys) begin
            n_ctl.status       = sys ? ST_SYS : ST_ILL;
            n_ctl.dest_write   = 1'b0;
            n_ctl.next_address = pc4;
            n_ctl.mem_kind     = MEM_NONE;
            n_ctl.mem_size_log = 2'd0;
            n_ctl.mem_zero_extend = 1'b0;
            n_ctl.mem_address  = 64'b0;
            n_ctl.store_data   = 64'b0;
        end
        if (n_ctl.dest_index == 5'd0) n_ctl.dest_write = 1'b0;

        // divider operands as magnitudes; word forms extend the low halves
        if (n_ctl.word) begin
            xa = dsign ? sx32(a) : {32'b0, a[31:0]};
            xb = dsign ? sx32(b) : {32'b0, b[31:0]};
        end else begin
            xa = a;
            xb = b;
        end
        n_dn = (dsign && xa[63]) ? -xa : xa;
        n_dd = (dsign && xb[63]) ? -xb : xb;
        n_ctl.neg_q = dsign && (xa[63] ^ xb[63]) && (xb != 64'b0);
        n_ctl.neg_r = dsign && xa[63];
    end

    assign s_adv   = !(r_out_vld && i_stall);
    assign o_stall = !s_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (s_adv) begin
            r_vld     <= {r_vld[DIV_STEPS-1:0], i_valid};
            r_out_vld <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_ctl[0] <= n_ctl;
            r_val[0] <= n_val;
            r_ma     <= a;
            r_mb     <= b;
            r_msa    <= n_msa;
            r_msb    <= n_msb;
            r_mhi    <= n_mhi;
            r_dn     <= n_dn;
            r_dd     <= n_dd;
        end
    end

    logic [63:0] s_mul, s_q, s_r;

    rvx_mul u_mul (
        .i_clk (i_clk),
        .i_en  (s_adv),
        .i_a   (r_ma),
        .i_b   (r_mb),
        .i_sa  (r_msa),
        .i_sb  (r_msb),
        .i_hi  (r_mhi),
        .o_res (s_mul)
    );

    rvx_div u_div (
        .i_clk (i_clk),
        .i_en  (s_adv),
        .i_n   (r_dn),
        .i_d   (r_dd),
        .o_q   (s_q),
        .o_r   (s_r)
    );

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (s_adv) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
        if (k == MUL_STAGE) begin : g_mul
            always_ff @(posedge i_clk) begin
                if (s_adv) begin
                    r_val[k] <= (r_ctl[k-1].rsel == RSEL_MUL) ? s_mul : r_val[k-1];
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (s_adv) begin
                    r_val[k] <= r_val[k-1];
                end
            end
        end
    end

    // result select, sign fix-up and word extension
    t_ctl        f_ctl;
    logic [63:0] f_pre, f_res;
    t_out        n_out;

    always_comb begin
        f_ctl = r_ctl[DIV_STEPS];
        unique case (f_ctl.rsel)
            RSEL_QUO: f_pre = f_ctl.neg_q ? -s_q : s_q;
            RSEL_REM: f_pre = f_ctl.neg_r ? -s_r : s_r;
            default:  f_pre = r_val[DIV_STEPS];
        endcase
        f_res = f_ctl.word ? sx32(f_pre) : f_pre;

        n_out.dest_index      = f_ctl.dest_index;
        n_out.dest_write      = f_ctl.dest_write;
        n_out.dest_value      = f_ctl.dest_write ? f_res : 64'b0;
        n_out.next_address    = f_ctl.next_address;
        n_out.mem_kind        = f_ctl.mem_kind;
        n_out.mem_size_log    = f_ctl.mem_size_log;
        n_out.mem_zero_extend = f_ctl.mem_zero_extend;
        n_out.mem_address     = f_ctl.mem_address;
        n_out.store_data      = f_ctl.store_data;
        n_out.status          = f_ctl.status;
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
